// File: rtl/fpfa_pkg.sv
// Shared types and constants of the fixed-partition fit allocator.
// No dependencies; used by the top level fixed_partition_fit_allocator.
package fpfa_pkg;

  // Widths of the stream fields.
  localparam int unsigned SizeW    = 16;
  localparam int unsigned IndexW   = 5;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  // Fit policy codes held in the configuration register.
  localparam logic [1:0] PolFirst = 2'd0;
  localparam logic [1:0] PolBest  = 2'd1;
  localparam logic [1:0] PolWorst = 2'd2;

  // Request kinds carried on the input tuser.
  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeAlloc = 1'b1;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

endpackage

// File: rtl/fixed_partition_fit_allocator.sv
// Fixed-partition allocator with first, best and worst fit policies.
// Depends on fpfa_pkg and on fpfa_ram for the partition size table.
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  ------------------------------------
//  s_axis    in   s_axis_tvalid/tready      tuser: mode; tdata: size
//  m_axis    out  m_axis_tvalid/tready      tuser: fit_found; tdata: index,
//                                           block size, leftover
//  cfg       in   cfg_valid/cfg_ready       cfg_data: fit_policy
//
// A load request writes the next size table entry while one is free. An
// allocate request scans the loaded partitions: the size table memory is
// read one entry per cycle, compared after its read, and the pick is posted.
// The result register lets a new request enter while the previous result
// waits; a stalled output holds the sequencer only when the next result is
// ready. Reset clears the count, the used flags, the policy and all valids.
module fixed_partition_fit_allocator #(
  parameter int unsigned BLOCKS    = 32,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Requests: tuser = mode; tdata = size[15:0].
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic                          s_axis_tuser_i,
  input  logic [fpfa_pkg::InDataW-1:0]  s_axis_tdata_i,
  // Results: tuser = fit_found; tdata = block_index[4:0], block_size[20:5],
  // leftover[36:21], zero [39:37].
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic                          m_axis_tuser_o,
  output logic [fpfa_pkg::OutDataW-1:0] m_axis_tdata_o,
  // Configuration: cfg_data = fit_policy.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_data_i
);

  localparam int unsigned IdxW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int unsigned CntW = $clog2(BLOCKS + 1);
  localparam int unsigned SzW  = fpfa_pkg::SizeW;
  localparam int unsigned IxW  = fpfa_pkg::IndexW;

  fpfa_pkg::state_e state_q, state_d;

  logic [1:0]           policy_q;
  logic [CntW-1:0]      count_q, count_d;
  logic [BLOCKS-1:0]    used_q;
  logic [SIZE_BITS-1:0] req_q, req_d;
  logic [CntW-1:0]      issue_q, issue_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]      cmp_idx_q, cmp_idx_d;
  logic                 found_q, found_d;
  logic [IdxW-1:0]      pick_q, pick_d;
  logic [SIZE_BITS-1:0] pick_size_q, pick_size_d;
  logic [SIZE_BITS-1:0] pick_left_q, pick_left_d;

  logic                 out_valid_q;
  logic                 out_found_q;
  logic [IxW-1:0]       out_index_q;
  logic [SzW-1:0]       out_size_q;
  logic [SzW-1:0]       out_left_q;

  logic                 in_fire;
  logic                 do_load;
  logic                 do_alloc;
  logic                 issue_more;
  logic                 post_go;
  logic                 ram_we;
  logic [IdxW-1:0]      ram_addr;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic [SIZE_BITS-1:0] in_size;
  logic [SIZE_BITS+SzW-1:0] in_size_ext;
  logic                 cand_fit;
  logic [SIZE_BITS-1:0] cand_left;
  logic                 cand_take;
  logic [IdxW+IxW-1:0]  pick_ext;
  logic [SIZE_BITS+SzW-1:0] size_ext;
  logic [SIZE_BITS+SzW-1:0] left_ext;

  // Input request decode; sizes are held to SIZE_BITS bits.
  assign in_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign do_load     = in_fire && (s_axis_tuser_i == fpfa_pkg::ModeLoad);
  assign do_alloc    = in_fire && (s_axis_tuser_i == fpfa_pkg::ModeAlloc);
  assign in_size_ext = {{SIZE_BITS{1'b0}}, s_axis_tdata_i[SzW-1:0]};
  assign in_size     = in_size_ext[SIZE_BITS-1:0];
  assign issue_more  = (issue_q < count_q);
  assign post_go     = !out_valid_q || m_axis_tready_i;

  // Size table: written by loads, read once per cycle during a scan.
  assign ram_we   = do_load && (count_q < CntW'(BLOCKS));
  assign ram_addr = (state_q == fpfa_pkg::ST_IDLE) ? count_q[IdxW-1:0]
                                                   : issue_q[IdxW-1:0];

  fpfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (BLOCKS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_size),
    .rdata_o (ram_rdata)
  );

  // Candidate evaluation on the entry read in the previous cycle.
  assign cand_fit  = cmp_vld_q && !used_q[cmp_idx_q] && (ram_rdata >= req_q);
  assign cand_left = ram_rdata - req_q;

  always_comb begin
    cand_take = 1'b0;
    if (cand_fit) begin
      if (!found_q) begin
        cand_take = 1'b1;
      end else begin
        case (policy_q)
          fpfa_pkg::PolBest:  cand_take = (cand_left < pick_left_q);
          fpfa_pkg::PolWorst: cand_take = (cand_left > pick_left_q);
          default:            cand_take = 1'b0;
        endcase
      end
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fpfa_pkg::ST_IDLE: begin
        if (do_alloc) begin
          state_d = fpfa_pkg::ST_SCAN;
        end
      end
      fpfa_pkg::ST_SCAN: begin
        if (!issue_more && !cmp_vld_q) begin
          state_d = fpfa_pkg::ST_RESULT;
        end
      end
      fpfa_pkg::ST_RESULT: begin
        if (post_go) begin
          state_d = fpfa_pkg::ST_IDLE;
        end
      end
      default: state_d = fpfa_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls of the sequencer.
  always_comb begin
    count_d     = count_q;
    req_d       = req_q;
    issue_d     = issue_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    pick_d      = pick_q;
    pick_size_d = pick_size_q;
    pick_left_d = pick_left_q;
    case (state_q)
      fpfa_pkg::ST_IDLE: begin
        if (ram_we) begin
          count_d = count_q + CntW'(1);
        end
        if (do_alloc) begin
          req_d   = in_size;
          issue_d = '0;
          found_d = 1'b0;
        end
      end
      fpfa_pkg::ST_SCAN: begin
        if (issue_more) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[IdxW-1:0];
          issue_d   = issue_q + CntW'(1);
        end
        if (cand_take) begin
          found_d     = 1'b1;
          pick_d      = cmp_idx_q;
          pick_size_d = ram_rdata;
          pick_left_d = cand_left;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fpfa_pkg::ST_IDLE;
      policy_q  <= fpfa_pkg::PolFirst;
      count_q   <= '0;
      used_q    <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_data_i;
      end
      if (state_q == fpfa_pkg::ST_RESULT && post_go) begin
        out_valid_q <= 1'b1;
        if (found_q) begin
          used_q[pick_q] <= 1'b1;
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  assign pick_ext = {{IxW{1'b0}}, pick_q};
  assign size_ext = {{SzW{1'b0}}, pick_size_q};
  assign left_ext = {{SzW{1'b0}}, pick_left_q};

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    issue_q     <= issue_d;
    cmp_idx_q   <= cmp_idx_d;
    pick_q      <= pick_d;
    pick_size_q <= pick_size_d;
    pick_left_q <= pick_left_d;
    if (state_q == fpfa_pkg::ST_RESULT && post_go) begin
      out_found_q <= found_q;
      out_index_q <= found_q ? pick_ext[IxW-1:0] : '0;
      out_size_q  <= found_q ? size_ext[SzW-1:0] : '0;
      out_left_q  <= found_q ? left_ext[SzW-1:0] : '0;
    end
  end

  // Port drive.
  assign s_axis_tready_o = (state_q == fpfa_pkg::ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_found_q;
  assign m_axis_tdata_o  = {3'b000, out_left_q, out_size_q, out_index_q};

  // A compare slot only exists while a scan is running.
  a_cmp_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == fpfa_pkg::ST_SCAN))
    else $error("compare slot valid outside a scan");

  // The table never holds more partitions than it has entries.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(BLOCKS))
    else $error("partition count beyond table depth");

  // A granted partition was free and large enough.
  a_grant_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpfa_pkg::ST_RESULT && found_q) |->
      (!used_q[pick_q] && (pick_size_q >= req_q)))
    else $error("granted partition is used or too small");

  // Posting a grant marks its partition used in the next cycle.
  a_grant_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpfa_pkg::ST_RESULT && post_go && found_q) |=>
      used_q[$past(pick_q)])
    else $error("granted partition not marked used");

endmodule

// File: rtl/fpfa_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies; holds the partition size table of the allocator.
module fpfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                    wdata_i,
  output logic [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write if enabled; the read always returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
